// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// ===== hdl/vurd_pkg.sv =====
package vurd_pkg;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;

	localparam logic [1:0] PH_HIGH = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_MARK = 2'd3;

	typedef struct packed {
		logic [7:0] buffer_byte;
		logic       end_of_buffer;
	} update_beat_t;

	typedef struct packed {
		logic [15:0] write_address;
		logic [7:0]  write_data;
	} write_beat_t;

endpackage

// ===== hdl/vurd_stream_if.sv =====
interface vurd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/vram_update_record_decoder.sv =====
// Video memory update record decoder.
// The updates channel carries one byte of the update buffer per beat, with
// end_of_buffer set on the last byte of a batch. Records are an address high
// byte, an address low byte and data bytes ended by a single 0xFF marker; a
// doubled 0xFF stands for a data byte of 0xFF.
// The writes channel carries one beat of write_address and write_data for
// every data byte, in buffer order; marker and address bytes give no beat.
// A byte is taken into an input register, parsed against the current phase
// and address, and its write is registered in an output register, from
// which it is offered on the writes channel.
// Throughput is one byte per cycle, set by the single parse stage, while the writes channel does not stall.
// When the receiver stalls, the pending write holds and the input register
// keeps accepting bytes that give no write; a byte that gives a write waits
// in the input register, and updates.ready drops until the output frees.
// end_of_buffer returns the parser to the address high byte phase with
// address zero after its byte. Reset does the same and empties both stages.
module vram_update_record_decoder
	import vurd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	vurd_stream_if.sink         updates,
	vurd_stream_if.source       writes
);

	logic         valid_s1;
	update_beat_t beat_s1;

	logic [1:0]   phase_q;
	logic [15:0]  addr_q;
	logic         res_valid_q;
	write_beat_t  res_q;

	logic [1:0]   phase_n;
	logic [15:0]  addr_n;
	logic         emit;
	write_beat_t  res_n;
	logic         adv;
	logic         take;

	always_comb begin
		phase_n = phase_q;
		addr_n  = addr_q;
		emit    = 1'b0;
		res_n.write_address = addr_q;
		res_n.write_data    = beat_s1.buffer_byte;
		case (phase_q)
			PH_HIGH: begin
				addr_n  = {beat_s1.buffer_byte, 8'h00};
				phase_n = PH_LOW;
			end
			PH_LOW: begin
				addr_n  = {addr_q[15:8], beat_s1.buffer_byte};
				phase_n = PH_DATA;
			end
			PH_DATA: begin
				if (beat_s1.buffer_byte == MARKER_BYTE) begin
					phase_n = PH_MARK;
				end else begin
					emit   = 1'b1;
					addr_n = addr_q + 16'd1;
				end
			end
			PH_MARK: begin
				if (beat_s1.buffer_byte == MARKER_BYTE) begin
					emit    = 1'b1;
					addr_n  = addr_q + 16'd1;
					phase_n = PH_DATA;
				end else begin
					addr_n  = {beat_s1.buffer_byte, 8'h00};
					phase_n = PH_LOW;
				end
			end
			default: begin
				phase_n = PH_HIGH;
			end
		endcase
		if (beat_s1.end_of_buffer) begin
			phase_n = PH_HIGH;
			addr_n  = 16'h0000;
		end
	end

	assign adv           = valid_s1 && (!emit || !res_valid_q || writes.ready);
	assign updates.ready = !valid_s1 || adv;
	assign take          = updates.valid && updates.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= updates.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HIGH;
			addr_q  <= 16'h0000;
		end else if (adv) begin
			phase_q <= phase_n;
			addr_q  <= addr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (writes.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res_n;
		end
	end

	assign writes.valid = res_valid_q;
	assign writes.data  = res_q;

endmodule

// ===== hdl/vurd_checker.sv =====
`include "assert_macros.svh"

module vurd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// A held write beat must stay offered until it is taken.
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	// The byte side only stalls while a write beat waits on the receiver.
	`ASSERT_CLK(a_stall_cause, clk, arst_n, !in_ready |-> out_valid && !out_ready)
	// No write beat is offered while reset is applied.
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid)

endmodule

bind vram_update_record_decoder vurd_checker u_vurd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (updates.ready),
	.out_valid (writes.valid),
	.out_ready (writes.ready)
);

// ===== test/tb_top.sv =====
package vurd_tb_pkg;
	import vurd_pkg::*;

	class vram_write_scoreboard;
		logic [1:0]  phase;
		logic [15:0] next_address;
		write_beat_t expected_writes[$];
		int          mismatches;

		function new();
			phase = PH_HIGH;
			next_address = '0;
			mismatches = 0;
		endfunction

		function void push_write(logic [7:0] value);
			write_beat_t w;
			w.write_address = next_address;
			w.write_data = value;
			expected_writes.push_back(w);
			next_address = next_address + 16'd1;
		endfunction

		// Follows the record parser for one accepted update beat.
		function void note_update(update_beat_t b);
			case (phase)
				PH_HIGH: begin
					next_address = {b.buffer_byte, 8'h00};
					phase = PH_LOW;
				end
				PH_LOW: begin
					next_address[7:0] = b.buffer_byte;
					phase = PH_DATA;
				end
				PH_DATA: begin
					if (b.buffer_byte == MARKER_BYTE)
						phase = PH_MARK;
					else
						push_write(b.buffer_byte);
				end
				default: begin
					if (b.buffer_byte == MARKER_BYTE) begin
						push_write(MARKER_BYTE);
						phase = PH_DATA;
					end else begin
						next_address = {b.buffer_byte, 8'h00};
						phase = PH_LOW;
					end
				end
			endcase
			if (b.end_of_buffer) begin
				phase = PH_HIGH;
				next_address = '0;
			end
		endfunction

		function void check_write(write_beat_t got);
			write_beat_t want;
			if (expected_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected write: address %h data %h",
						got.write_address, got.write_data);
			end else begin
				want = expected_writes.pop_front();
				if (got.write_address !== want.write_address ||
					got.write_data !== want.write_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("write mismatch: expected %h/%h, got %h/%h",
							want.write_address, want.write_data,
							got.write_address, got.write_data);
				end
			end
		endfunction

		function int pending();
			return expected_writes.size();
		endfunction
	endclass
endpackage

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vurd_pkg::*;
	import vurd_tb_pkg::*;

	logic clk;
	logic arst_n;

	vurd_stream_if #(.T(update_beat_t)) updates_if ();
	vurd_stream_if #(.T(write_beat_t))  writes_if ();

	vram_update_record_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.updates(updates_if),
		.writes (writes_if)
	);

	vram_write_scoreboard sb;
	update_beat_t         update_bytes[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_600_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (updates_if.valid && updates_if.ready)
				sb.note_update(updates_if.data);
			if (writes_if.valid && writes_if.ready)
				sb.check_write(writes_if.data);
		end
	end

	// The receiver draws a new stall rate periodically and holds off for
	// a long stretch once, so that the decoder fills up and stalls its input.
	initial begin
		int cycle;
		int stall_pct;
		writes_if.ready = 1'b0;
		cycle = 0;
		stall_pct = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle >= 1000 && cycle < 1120) begin
				writes_if.ready = 1'b0;
			end else begin
				if (cycle % 256 == 0)
					case ($urandom_range(4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				writes_if.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic add_byte(logic [7:0] value, logic last = 1'b0);
		update_beat_t b;
		b.buffer_byte = value;
		b.end_of_buffer = last;
		update_bytes.push_back(b);
	endtask

	task automatic end_batch();
		update_beat_t b;
		b = update_bytes.pop_back();
		b.end_of_buffer = 1'b1;
		update_bytes.push_back(b);
	endtask

	// Mostly well-formed batches of records with random content; about one
	// batch in eight is noise.
	task automatic add_random_batch();
		int records;
		int count;
		logic [7:0] value;
		if ($urandom_range(7) == 0) begin
			count = $urandom_range(1, 12);
			repeat (count) begin
				if ($urandom_range(2) == 0)
					add_byte(MARKER_BYTE);
				else
					add_byte(8'($urandom_range(255)));
			end
		end else begin
			records = $urandom_range(1, 4);
			for (int r = 0; r < records; r++) begin
				if ($urandom_range(9) == 0) begin
					add_byte(r == 0 ? MARKER_BYTE : 8'hFE);
					add_byte(8'($urandom_range(8'hF8, 8'hFF)));
				end else begin
					add_byte(r == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(254)));
					add_byte(8'($urandom_range(255)));
				end
				count = $urandom_range(0, 10);
				for (int i = 0; i < count; i++) begin
					value = ($urandom_range(7) == 0) ? MARKER_BYTE : 8'($urandom_range(255));
					add_byte(value);
					if (value == MARKER_BYTE)
						add_byte(MARKER_BYTE);
				end
				if (r != records - 1 || $urandom_range(3) != 0)
					add_byte(MARKER_BYTE);
			end
		end
		end_batch();
	endtask

	task automatic send_update(update_beat_t b);
		@(negedge clk);
		updates_if.valid = 1'b1;
		updates_if.data = b;
		do @(posedge clk); while (!updates_if.ready);
	endtask

	task automatic pause_updates(int cycles);
		@(negedge clk);
		updates_if.valid = 1'b0;
		updates_if.data = 9'($urandom_range(511));
		repeat (cycles - 1) @(negedge clk);
	endtask

	initial begin
		int burst_left;
		sb = new();
		arst_n = 1'b1;
		updates_if.valid = 1'b0;
		updates_if.data = '0;

		// Address wrap, doubled marker, marker then a new record, marker last.
		add_byte(8'hFF); add_byte(8'hFE); add_byte(8'h00);
		add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h7F);
		add_byte(8'hAA); add_byte(8'h55); add_byte(8'hFF);
		add_byte(8'h12); add_byte(8'h34); add_byte(8'h01);
		add_byte(8'hFF, 1'b1);
		// End of buffer in the high, low and data phases.
		add_byte(8'h80, 1'b1);
		add_byte(8'h00); add_byte(8'h00, 1'b1);
		add_byte(8'h00); add_byte(8'h10); add_byte(8'h5A); add_byte(8'h01, 1'b1);
		// Doubled marker as the last beat of a batch.
		add_byte(8'h3C); add_byte(8'hC3); add_byte(8'hFF); add_byte(8'hFF, 1'b1);

		while (update_bytes.size() < 1223)
			add_random_batch();

		#1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		burst_left = $urandom_range(1, 20);
		for (int i = 0; i < update_bytes.size(); i++) begin
			if ((i / 100) % 4 != 3) begin
				if (burst_left == 0) begin
					pause_updates($urandom_range(1, 6));
					burst_left = $urandom_range(1, 20);
				end
				burst_left--;
			end
			send_update(update_bytes[i]);
		end
		@(negedge clk);
		updates_if.valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
